// ===== design/pce_pkg.sv =====
`default_nettype none
// ============================================================================
// pce_pkg
// Shared types and constants of the candidate enumerator: item layouts,
// operation and register codes, state encodings and internal control bundles.
// ============================================================================
package pce_pkg;

    // Defaults of the top-level parameters
    localparam int ALPHA_MAX_DEF = 256;
    localparam int MAX_LEN_DEF   = 16;

    // Fixed field widths
    localparam int SEED_W  = 64;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 8;
    localparam int LEN_W   = 5;
    localparam int POS_W   = 4;
    localparam int RADIX_W = 9;
    localparam int CFG_W   = 32;
    localparam int PADDR_W = 3;

    // Seed divider: bits retired per cycle, and the bound and width of its counter
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = SEED_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SEED = 2'd1,
        OP_STEP = 2'd2
    } pce_op_t;

    typedef enum logic {
        REG_ALPHA_SIZE = 1'b0,
        REG_MAX_LEN    = 1'b1
    } pce_reg_t;

    typedef struct packed {
        pce_op_t             operation;
        logic [7:0]          symbol_index;
        logic [CHAR_W-1:0]   symbol_char;
        logic [SEED_W-1:0]   seed_number;
    } pce_in_t;

    typedef struct packed {
        logic [POS_W-1:0]    char_position;
        logic [CHAR_W-1:0]   char_value;
        logic [LEN_W-1:0]    cand_length;
        logic                last_char;
        logic                exhausted;
    } pce_out_t;

    // Digit store write request
    typedef struct packed {
        logic                we;
        logic [LEN_W-1:0]    addr;
        logic [DIGIT_W-1:0]  data;
    } pce_dwr_t;

    // Seed conversion status, one-cycle pulse on fin
    typedef struct packed {
        logic                fin;
        logic                over;
        logic [LEN_W-1:0]    len;
    } pce_seed_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_EMIT,
        ST_FINISH
    } pce_state_t;

    typedef enum logic [1:0] {
        SD_IDLE,
        SD_SEARCH,
        SD_DIVIDE
    } pce_seed_state_t;

endpackage
`default_nettype wire

// ===== design/pce_alpha_ram.sv =====
`default_nettype none
// ============================================================================
// pce_alpha_ram
// Alphabet symbol store: one write port, one read port, registered read data.
// ============================================================================
module pce_alpha_ram
    import pce_pkg::*;
#(
    parameter int DEPTH = ALPHA_MAX_DEF,
    parameter int AW    = $clog2(ALPHA_MAX_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [CHAR_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem_reg [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    // Write one symbol, read one symbol per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/pce_digit_ram.sv =====
`default_nettype none
// ============================================================================
// pce_digit_ram
// Digit index store with per-entry valid bits: an entry not yet written since
// reset reads as zero. Registered read data.
// ============================================================================
module pce_digit_ram
    import pce_pkg::*;
#(
    parameter int DEPTH = MAX_LEN_DEF,
    parameter int AW    = $clog2(MAX_LEN_DEF)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [DIGIT_W-1:0] wdata,
    input  wire logic [AW-1:0]      raddr,
    output logic      [DIGIT_W-1:0] rdata
);

    logic [DIGIT_W-1:0] mem_reg [DEPTH];
    logic [DIGIT_W-1:0] rdata_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic               rvalid_reg;

    // Store data; the read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    // Track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // Mask entries left at their reset value
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule
`default_nettype wire

// ===== design/pce_seed_unit.sv =====
`default_nettype none
// ============================================================================
// pce_seed_unit
// Bijective base-N conversion of a seed number: a length search that peels
// off one radix power per cycle, then a long division by the radix that
// retires four bits per cycle and writes one digit per full pass over the number.
// ============================================================================
module pce_seed_unit
    import pce_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [SEED_W-1:0]  number,
    input  wire logic [RADIX_W-1:0] radix,
    input  wire logic [LEN_W-1:0]   limit,
    output pce_dwr_t                dwr,
    output pce_seed_res_t           res
);

    localparam int PROD_W = SEED_W + RADIX_W;

    pce_seed_state_t state_reg, state_next;

    logic [SEED_W-1:0]    num_reg, num_next;
    logic [SEED_W-1:0]    pwr_reg, pwr_next;
    logic                 big_reg, big_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     pos_reg, pos_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic [LEN_W-1:0]     lim_reg, lim_next;
    pce_seed_res_t        res_reg, res_next;

    logic [PROD_W-1:0]    prod;
    logic                 search_go;
    logic                 last_cycle;
    logic                 last_digit;
    logic [RADIX_W-1:0]   div_rem;
    logic [SEED_W-1:0]    div_quo;

    // Next radix power and its overflow
    assign prod = {{RADIX_W{1'b0}}, pwr_reg} * {{SEED_W{1'b0}}, radix_reg};

    assign search_go  = !big_reg && (num_reg >= pwr_reg);
    assign last_cycle = (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));
    assign last_digit = (pos_reg == (len_reg - LEN_W'(1)));

    // Retire DIV_STEPS quotient bits per cycle
    always_comb
    begin
        logic [RADIX_W:0]  r;
        logic [SEED_W-1:0] q;
        r = {1'b0, rem_reg};
        q = num_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r = {r[RADIX_W-1:0], q[SEED_W-1]};
            q = {q[SEED_W-2:0], 1'b0};
            if (r >= {1'b0, radix_reg})
            begin
                r    = r - {1'b0, radix_reg};
                q[0] = 1'b1;
            end
        end
        div_rem = r[RADIX_W-1:0];
        div_quo = q;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SD_IDLE:
            begin
                if (start)
                begin
                    state_next = SD_SEARCH;
                end
            end
            SD_SEARCH:
            begin
                if (search_go)
                begin
                    if (len_reg >= lim_reg)
                    begin
                        state_next = SD_IDLE;
                    end
                end
                else if (len_reg > lim_reg)
                begin
                    state_next = SD_IDLE;
                end
                else
                begin
                    state_next = SD_DIVIDE;
                end
            end
            SD_DIVIDE:
            begin
                if (last_cycle && last_digit)
                begin
                    state_next = SD_IDLE;
                end
            end
            default:
            begin
                state_next = SD_IDLE;
            end
        endcase
    end

    // Outputs: digit write and completion status
    always_comb
    begin
        dwr.we   = (state_reg == SD_DIVIDE) && last_cycle;
        dwr.addr = pos_reg;
        dwr.data = div_rem[DIGIT_W-1:0];

        res_next.fin  = 1'b0;
        res_next.over = 1'b0;
        res_next.len  = len_reg;
        unique case (state_reg)
            SD_SEARCH:
            begin
                if ((search_go && (len_reg >= lim_reg)) || (!search_go && (len_reg > lim_reg)))
                begin
                    res_next.fin  = 1'b1;
                    res_next.over = 1'b1;
                end
            end
            SD_DIVIDE:
            begin
                res_next.fin = last_cycle && last_digit;
            end
            default:
            begin
                res_next.fin = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        num_next   = num_reg;
        pwr_next   = pwr_reg;
        big_next   = big_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        radix_next = radix_reg;
        lim_next   = lim_reg;
        case (state_reg)
            SD_IDLE:
            begin
                if (start)
                begin
                    num_next   = number;
                    pwr_next   = {{(SEED_W - RADIX_W){1'b0}}, radix};
                    big_next   = 1'b0;
                    len_next   = LEN_W'(1);
                    radix_next = radix;
                    lim_next   = limit;
                end
            end
            SD_SEARCH:
            begin
                pos_next = '0;
                rem_next = '0;
                cnt_next = '0;
                if (search_go && (len_reg < lim_reg))
                begin
                    num_next = num_reg - pwr_reg;
                    len_next = len_reg + LEN_W'(1);
                    if (prod[PROD_W-1:SEED_W] != '0)
                    begin
                        big_next = 1'b1;
                    end
                    else
                    begin
                        pwr_next = prod[SEED_W-1:0];
                    end
                end
            end
            SD_DIVIDE:
            begin
                num_next = div_quo;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (last_cycle)
                begin
                    rem_next = '0;
                    pos_next = pos_reg + LEN_W'(1);
                end
                else
                begin
                    rem_next = div_rem;
                end
            end
            default:
            begin
                num_next = num_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SD_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        pwr_reg   <= pwr_next;
        big_reg   <= big_next;
        len_reg   <= len_next;
        pos_reg   <= pos_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        radix_reg <= radix_next;
        lim_reg   <= lim_next;
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ===== design/password_candidate_enumerator_core.sv =====
`default_nettype none
// ============================================================================
// password_candidate_enumerator_core
// Brute-force candidate enumerator over a loaded alphabet, bijective base-N.
// ============================================================================
// Usage:
//   Drive cmd and raise start; the item is taken at an edge with busy low.
//   A load writes one alphabet symbol in the accept cycle and leaves busy low.
//   A seed converts cmd.seed_number to a length and digits and holds busy
//   through the length search over the radix powers, the divider (which
//   retires four bits of the 64-bit number per cycle and writes one digit
//   per full pass over the number) and the report of the result; a seed that
//   does not fit drops busy once its length search reaches the length limit.
//   A step emits one result per character on result/result_valid, least
//   significant first and one per cycle, each passing the registered digit
//   read and then the registered symbol read; busy stays high through the
//   emit and finish states, so no new item is taken before the step ends.
//   The digit store is read, incremented with carry and written back in the
//   same pass, one position per cycle, so a longer candidate holds busy longer.
//   An exhausted step gives a single result with exhausted set, in the cycle
//   after acceptance, and busy stays low.
//   Results show for one cycle each; the receiver cannot stall them.
//   Reset restores alphabet_size 26, max_length 8, length one, digits zero;
//   the alphabet must be loaded before use. The user must write registers
//   over the APB port only while the block is idle; it does not enforce this.
// ============================================================================
module password_candidate_enumerator_core
    import pce_pkg::*;
#(
    parameter int ALPHA_MAX = ALPHA_MAX_DEF,
    parameter int MAX_LEN   = MAX_LEN_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pce_in_t            cmd,
    output logic                    result_valid,
    output pce_out_t                result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]   pwdata,
    output logic      [CFG_W-1:0]   prdata,
    output logic                    pready
);

    localparam int A_AW = $clog2(ALPHA_MAX);
    localparam int D_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LEN_W-1:0]   LIM_CAP   = LEN_W'((MAX_LEN > 31) ? 31 : MAX_LEN);
    localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(ALPHA_MAX);

    pce_state_t state_reg, state_next;

    logic [RADIX_W-1:0] alpha_size_reg, alpha_size_next;
    logic [LEN_W-1:0]   max_len_reg, max_len_next;
    logic [LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic               done_reg, done_next;
    logic [LEN_W-1:0]   issue_pos_reg, issue_pos_next;
    logic               carry_reg, carry_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [LEN_W-1:0]   s1_pos_reg, s1_pos_next;
    logic               s1_last_reg, s1_last_next;
    logic               s2_valid_reg, s2_valid_next;
    logic [LEN_W-1:0]   s2_pos_reg, s2_pos_next;
    logic               s2_last_reg, s2_last_next;
    logic               s2_inrange_reg, s2_inrange_next;
    logic               exh_reg, exh_next;

    logic [RADIX_W-1:0] radix_eff;
    logic [LEN_W-1:0]   lim_eff;
    logic               accept;
    logic               cfg_write;
    logic               exhaust_cond;
    logic               issue;
    logic [DIGIT_W-1:0] digit_rdata;
    logic [CHAR_W-1:0]  alpha_rdata;
    logic [RADIX_W-1:0] digit_inc;
    logic               wraps;
    logic               load_we;
    logic               seed_start;
    pce_dwr_t           seed_dwr;
    pce_seed_res_t      seed_res;
    pce_dwr_t           step_dwr;
    pce_dwr_t           dig_wr;

    // Effective radix and length limit
    always_comb
    begin
        if (alpha_size_reg == '0)
        begin
            radix_eff = RADIX_W'(1);
        end
        else if (alpha_size_reg > RADIX_CAP)
        begin
            radix_eff = RADIX_CAP;
        end
        else
        begin
            radix_eff = alpha_size_reg;
        end
        lim_eff = (max_len_reg > LIM_CAP) ? LIM_CAP : max_len_reg;
    end

    assign accept       = start && !busy;
    assign busy         = (state_reg != ST_IDLE);
    assign exhaust_cond = done_reg || (cur_len_reg == '0) || (cur_len_reg > lim_eff);
    assign issue        = (state_reg == ST_EMIT) && (issue_pos_reg < cur_len_reg);
    assign load_we      = accept && (cmd.operation == OP_LOAD)
                          && ({1'b0, cmd.symbol_index} < RADIX_CAP);
    assign seed_start   = accept && (cmd.operation == OP_SEED);

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        alpha_size_next = alpha_size_reg;
        max_len_next    = max_len_reg;
        unique case (pce_reg_t'(paddr[2]))
            REG_ALPHA_SIZE:
            begin
                prdata = {{(CFG_W - RADIX_W){1'b0}}, alpha_size_reg};
                if (cfg_write)
                begin
                    alpha_size_next = pwdata[RADIX_W-1:0];
                end
            end
            REG_MAX_LEN:
            begin
                prdata = {{(CFG_W - LEN_W){1'b0}}, max_len_reg};
                if (cfg_write)
                begin
                    max_len_next = pwdata[LEN_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // Seed conversion unit
    pce_seed_unit u_seed (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (seed_start),
        .number (cmd.seed_number),
        .radix  (radix_eff),
        .limit  (lim_eff),
        .dwr    (seed_dwr),
        .res    (seed_res)
    );

    // Increment the digit read back for the position in stage one
    assign digit_inc = {1'b0, digit_rdata} + RADIX_W'(1);
    assign wraps     = !(digit_inc < radix_eff);

    // Step write: carry write-back during emit, new top digit at finish
    always_comb
    begin
        step_dwr.we   = 1'b0;
        step_dwr.addr = s1_pos_reg;
        step_dwr.data = wraps ? '0 : digit_inc[DIGIT_W-1:0];
        if (state_reg == ST_FINISH)
        begin
            step_dwr.we   = carry_reg && (cur_len_reg < lim_eff);
            step_dwr.addr = cur_len_reg;
            step_dwr.data = '0;
        end
        else if (s1_valid_reg)
        begin
            step_dwr.we = carry_reg;
        end
    end

    assign dig_wr = seed_dwr.we ? seed_dwr : step_dwr;

    pce_digit_ram #(
        .DEPTH (MAX_LEN),
        .AW    (D_AW)
    ) u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (dig_wr.we),
        .waddr (dig_wr.addr[D_AW-1:0]),
        .wdata (dig_wr.data),
        .raddr (issue_pos_reg[D_AW-1:0]),
        .rdata (digit_rdata)
    );

    pce_alpha_ram #(
        .DEPTH (ALPHA_MAX),
        .AW    (A_AW)
    ) u_alpha (
        .clk   (clk),
        .we    (load_we),
        .waddr (cmd.symbol_index[A_AW-1:0]),
        .wdata (cmd.symbol_char),
        .raddr (digit_rdata[A_AW-1:0]),
        .rdata (alpha_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.operation == OP_SEED)
                    begin
                        state_next = ST_SEED;
                    end
                    else if ((cmd.operation == OP_STEP) && !exhaust_cond)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SEED:
            begin
                if (seed_res.fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Emit pipeline and candidate state
    always_comb
    begin
        cur_len_next    = cur_len_reg;
        done_next       = done_reg;
        issue_pos_next  = issue_pos_reg;
        carry_next      = carry_reg;
        exh_next        = 1'b0;
        s1_valid_next   = issue;
        s1_pos_next     = issue_pos_reg;
        s1_last_next    = (issue_pos_reg == (cur_len_reg - LEN_W'(1)));
        s2_valid_next   = s1_valid_reg;
        s2_pos_next     = s1_pos_reg;
        s2_last_next    = s1_last_reg;
        s2_inrange_next = ({1'b0, digit_rdata} < RADIX_CAP);

        // Start a step or flag it exhausted
        if (accept && (cmd.operation == OP_STEP))
        begin
            issue_pos_next = '0;
            carry_next     = 1'b1;
            if (exhaust_cond)
            begin
                exh_next  = 1'b1;
                done_next = 1'b1;
            end
        end

        if (issue)
        begin
            issue_pos_next = issue_pos_reg + LEN_W'(1);
        end

        // Drop the carry once a digit absorbs it
        if (s1_valid_reg && carry_reg && !wraps)
        begin
            carry_next = 1'b0;
        end

        // Grow the length or run out
        if ((state_reg == ST_FINISH) && carry_reg)
        begin
            if (cur_len_reg < lim_eff)
            begin
                cur_len_next = cur_len_reg + LEN_W'(1);
            end
            else
            begin
                done_next = 1'b1;
            end
        end

        // Take the seed result
        if (seed_res.fin)
        begin
            if (seed_res.over)
            begin
                done_next = 1'b1;
            end
            else
            begin
                done_next    = 1'b0;
                cur_len_next = seed_res.len;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            alpha_size_reg <= RADIX_W'(26);
            max_len_reg    <= LEN_W'(8);
            cur_len_reg    <= LEN_W'(1);
            done_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            exh_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            alpha_size_reg <= alpha_size_next;
            max_len_reg    <= max_len_next;
            cur_len_reg    <= cur_len_next;
            done_reg       <= done_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            exh_reg        <= exh_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        issue_pos_reg  <= issue_pos_next;
        carry_reg      <= carry_next;
        s1_pos_reg     <= s1_pos_next;
        s1_last_reg    <= s1_last_next;
        s2_pos_reg     <= s2_pos_next;
        s2_last_reg    <= s2_last_next;
        s2_inrange_reg <= s2_inrange_next;
    end

    // Result item
    always_comb
    begin
        result_valid         = s2_valid_reg || exh_reg;
        result.char_position = s2_valid_reg ? s2_pos_reg[POS_W-1:0] : '0;
        result.char_value    = (s2_valid_reg && s2_inrange_reg) ? alpha_rdata : '0;
        result.cand_length   = s2_valid_reg ? cur_len_reg : '0;
        result.last_char     = s2_valid_reg && s2_last_reg;
        result.exhausted     = exh_reg;
    end

    // An exhausted result never meets a character result
    a_exh_alone: assert property (@(posedge clk) disable iff (!rst_n)
        !(exh_reg && s2_valid_reg))
        else $error("exhausted result overlaps a character result");

    // The digit store is written by one source at a time
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(seed_dwr.we && step_dwr.we))
        else $error("seed and step write the digit store together");

    // The final character ends the candidate
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |=> !s2_valid_reg)
        else $error("character result after the final character");

    // Carry write-back stays inside the candidate
    a_wb_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && step_dwr.we) |-> (step_dwr.addr < cur_len_reg))
        else $error("digit write-back beyond the current length");

endmodule
`default_nettype wire

// ===== bench/tb_password_candidate_enumerator_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_password_candidate_enumerator_core
// Self-checking bench for the brute-force candidate enumerator. A short table
// of directed items covers reset state, field extremes, clamped registers,
// seeds that do not fit and exhausted steps. A random stream of loads, seeds
// and step bursts follows, across several register settings. Every result is
// checked field by field against an in-bench counter model or its table row.
// ============================================================================
module tb_password_candidate_enumerator_core;
    import pce_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         PHASES        = 9;
    localparam int         PER_PHASE     = 40;
    localparam int         SETTLE_CYCLES = 300;
    localparam int         DIGITS        = 16;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam pce_out_t NO_CANDIDATE = '{char_position: '0, char_value: '0,
                                          cand_length: '0, last_char: 1'b0,
                                          exhausted: 1'b1};

    // Register settings visited by the random stream, one pair per phase
    localparam int PHASE_RADIX [PHASES] = '{26, 2, 1, 256, 3, 0, 511, 7, 4};
    localparam int PHASE_LEN   [PHASES] = '{8, 16, 5, 16, 3, 31, 2, 0, 16};

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    pce_in_t             cmd     = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [CFG_W-1:0]    pwdata  = '0;
    logic                busy;
    logic                result_valid;
    pce_out_t            result;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    password_candidate_enumerator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // Counter model state
    logic [7:0]  alpha_mem    [256];
    bit          alpha_loaded [256];
    logic [7:0]  digit_mem    [DIGITS];
    int          cur_len;
    bit          spent;
    logic [8:0]  radix_reg;
    logic [4:0]  maxlen_reg;

    pce_out_t    expected_chars [$];
    int          err_count       = 0;
    int          item_count      = 0;
    int          char_count      = 0;
    int          exhausted_count = 0;
    int          longest         = 0;
    bit          steady_stretch  = 1'b0;

    typedef struct {
        bit          is_cfg;
        pce_reg_t    cfg_sel;
        logic [31:0] cfg_val;
        pce_in_t     cmd;
        bit          typed;
        pce_out_t    want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic logic [63:0] eff_radix();
        if (radix_reg == 0)
            return 64'd1;
        if (radix_reg > 256)
            return 64'd256;
        return 64'(radix_reg);
    endfunction

    function automatic int eff_limit();
        return (maxlen_reg > DIGITS) ? DIGITS : int'(maxlen_reg);
    endfunction

    function automatic bit step_exhausted();
        return spent || cur_len == 0 || cur_len > eff_limit();
    endfunction

    // Increment the little-endian digits with carry; grow or mark exhausted
    function automatic void advance_counter();
        logic [63:0] rdx;
        logic [8:0]  d;
        rdx = eff_radix();
        for (int i = 0; i < cur_len && i < DIGITS; i++)
        begin
            d = 9'(digit_mem[i]) + 9'd1;
            if (64'(d) < rdx)
            begin
                digit_mem[i] = d[7:0];
                return;
            end
            digit_mem[i] = '0;
        end
        if (cur_len < eff_limit())
        begin
            digit_mem[cur_len] = '0;
            cur_len++;
        end
        else
            spent = 1'b1;
    endfunction

    // Bijective base-N conversion of a combination number
    function automatic void seed_counter(logic [63:0] num);
        logic [63:0] rdx;
        logic [63:0] pw;
        bit          big;
        bit          over;
        int          len;
        int          lim;
        rdx  = eff_radix();
        lim  = eff_limit();
        pw   = rdx;
        big  = 1'b0;
        over = 1'b0;
        len  = 1;
        while (!big && num >= pw)
        begin
            if (len >= lim)
            begin
                over = 1'b1;
                break;
            end
            num -= pw;
            if (pw > ALL_ONES / rdx)
                big = 1'b1;
            else
                pw *= rdx;
            len++;
        end
        if (over || len > lim)
        begin
            spent = 1'b1;
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            digit_mem[i] = 8'(num % rdx);
            num /= rdx;
        end
        cur_len = len;
        spent   = 1'b0;
    endfunction

    // Apply one accepted item to the model and collect its characters
    function automatic void model_item(input pce_in_t c, output pce_out_t outs [$]);
        pce_out_t o;
        outs = {};
        case (c.operation)
            OP_LOAD:
            begin
                alpha_mem[c.symbol_index]    = c.symbol_char;
                alpha_loaded[c.symbol_index] = 1'b1;
            end
            OP_SEED:
                seed_counter(c.seed_number);
            OP_STEP:
            begin
                if (step_exhausted())
                begin
                    spent = 1'b1;
                    outs.push_back(NO_CANDIDATE);
                end
                else
                begin
                    for (int i = 0; i < cur_len; i++)
                    begin
                        o.char_position = 4'(i);
                        o.char_value    = alpha_mem[digit_mem[i]];
                        o.cand_length   = 5'(cur_len);
                        o.last_char     = (i + 1 == cur_len);
                        o.exhausted     = 1'b0;
                        outs.push_back(o);
                    end
                    advance_counter();
                end
            end
            default:
                ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Hand one item to the block, predict it on acceptance, then maybe idle
    task automatic send_item(input pce_in_t c, input bit typed = 1'b0,
                             input pce_out_t want = '0);
        pce_out_t outs [$];
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        model_item(c, outs);
        item_count++;
        if (typed)
            expected_chars.push_back(want);
        else
            foreach (outs[i])
                expected_chars.push_back(outs[i]);
        if (!steady_stretch && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Load every alphabet entry the next step would read that was never written
    task automatic load_missing();
        pce_in_t c;
        if (step_exhausted())
            return;
        for (int i = 0; i < cur_len; i++)
        begin
            if (!alpha_loaded[digit_mem[i]])
            begin
                c              = '0;
                c.operation    = OP_LOAD;
                c.symbol_index = digit_mem[i];
                c.symbol_char  = 8'($urandom);
                send_item(c);
            end
        end
    endtask

    // Drop start and wait for all characters; optionally let a seed finish too
    task automatic settle(input bit for_config);
        start <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        if (for_config)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input pce_reg_t sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (sel)
            REG_ALPHA_SIZE: radix_reg  = val[8:0];
            REG_MAX_LEN:    maxlen_reg = val[4:0];
            default:        ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_row(input logic [1:0] op, input logic [7:0] idx,
                                    input logic [7:0] ch, input logic [63:0] seed_num,
                                    input bit typed = 1'b0, input pce_out_t want = '0);
        dir_row_t r;
        r.is_cfg              = 1'b0;
        r.cfg_sel             = REG_ALPHA_SIZE;
        r.cfg_val             = '0;
        r.cmd.operation       = pce_op_t'(op);
        r.cmd.symbol_index    = idx;
        r.cmd.symbol_char     = ch;
        r.cmd.seed_number     = seed_num;
        r.typed               = typed;
        r.want                = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input pce_reg_t sel, input logic [31:0] val);
        dir_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_sel = sel;
        r.cfg_val = val;
        r.cmd     = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        dir_rows.push_back(r);
    endfunction

    // Check each character against the oldest expectation
    always @(posedge clk)
    begin
        pce_out_t want;
        if (rst_n && result_valid)
        begin
            if (result.exhausted)
                exhausted_count++;
            else
                char_count++;
            if (result.last_char && int'(result.cand_length) > longest)
                longest = int'(result.cand_length);
            if (expected_chars.size() == 0)
                report_mismatch("character with nothing expected", 64'(result), '0);
            else
            begin
                want = expected_chars.pop_front();
                if (result.char_position !== want.char_position)
                    report_mismatch("char_position", 64'(result.char_position),
                                    64'(want.char_position));
                if (result.char_value !== want.char_value)
                    report_mismatch("char_value", 64'(result.char_value),
                                    64'(want.char_value));
                if (result.cand_length !== want.cand_length)
                    report_mismatch("cand_length", 64'(result.cand_length),
                                    64'(want.cand_length));
                if (result.last_char !== want.last_char)
                    report_mismatch("last_char", 64'(result.last_char),
                                    64'(want.last_char));
                if (result.exhausted !== want.exhausted)
                    report_mismatch("exhausted", 64'(result.exhausted),
                                    64'(want.exhausted));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        pce_in_t     c;
        logic [63:0] rdx;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] seed_num;
        int          pick;
        int          burst;
        int          reach;

        // Model reset state
        radix_reg  = 9'd26;
        maxlen_reg = 5'd8;
        cur_len    = 1;
        spent      = 1'b0;
        burst      = 0;
        foreach (digit_mem[i])
            digit_mem[i] = '0;
        foreach (alpha_loaded[i])
        begin
            alpha_loaded[i] = 1'b0;
            alpha_mem[i]    = '0;
        end

        // Directed items: reset state, extremes, clamps, overflow, exhaustion
        add_row(OP_LOAD, 8'd0,   8'h61, '0);
        add_row(OP_LOAD, 8'd1,   8'h00, '0);
        add_row(OP_LOAD, 8'd255, 8'hFF, '0);
        add_row(OP_LOAD, 8'd25,  8'h7A, '0);
        add_row(OP_STEP, '0, '0, '0, 1'b1, '{char_position: 4'd0, char_value: 8'h61,
                cand_length: 5'd1, last_char: 1'b1, exhausted: 1'b0});
        add_row(OP_STEP, '0, '0, '0, 1'b1, '{char_position: 4'd0, char_value: 8'h00,
                cand_length: 5'd1, last_char: 1'b1, exhausted: 1'b0});
        add_row(OP_SEED, '0, '0, 64'd25);
        add_row(OP_STEP, '0, '0, '0, 1'b1, '{char_position: 4'd0, char_value: 8'h7A,
                cand_length: 5'd1, last_char: 1'b1, exhausted: 1'b0});
        add_row(OP_STEP, '0, '0, '0);
        add_row(OP_UNUSED, 8'hA5, 8'h5A, 64'hDEAD_BEEF_0123_4567);
        add_cfg(REG_MAX_LEN, 32'd0);
        add_row(OP_STEP, '0, '0, '0, 1'b1, NO_CANDIDATE);
        add_cfg(REG_MAX_LEN, 32'd31);
        add_row(OP_SEED, '0, '0, ALL_ONES);
        add_row(OP_STEP, '0, '0, '0);
        add_cfg(REG_ALPHA_SIZE, 32'd0);
        add_row(OP_SEED, '0, '0, 64'd0);
        add_row(OP_STEP, '0, '0, '0, 1'b1, '{char_position: 4'd0, char_value: 8'h61,
                cand_length: 5'd1, last_char: 1'b1, exhausted: 1'b0});
        add_row(OP_SEED, '0, '0, ALL_ONES);
        add_row(OP_STEP, '0, '0, '0, 1'b1, NO_CANDIDATE);
        add_cfg(REG_ALPHA_SIZE, 32'd511);
        add_row(OP_SEED, '0, '0, ALL_ONES);
        add_row(OP_STEP, '0, '0, '0);
        add_row(OP_SEED, '0, '0, 64'd200);
        add_cfg(REG_ALPHA_SIZE, 32'd10);
        add_cfg(REG_MAX_LEN, 32'd1);
        add_row(OP_STEP, '0, '0, '0);
        add_row(OP_STEP, '0, '0, '0, 1'b1, NO_CANDIDATE);

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
            begin
                settle(1'b1);
                write_reg(dir_rows[r].cfg_sel, dir_rows[r].cfg_val);
            end
            else
            begin
                if (dir_rows[r].cmd.operation == OP_STEP && !dir_rows[r].typed)
                    load_missing();
                send_item(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // Random stream: seeds followed by step bursts, loads and unused codes
        for (int n = 0; n < PHASES * PER_PHASE; n++)
        begin
            if (n % PER_PHASE == 0)
            begin
                settle(1'b1);
                write_reg(REG_ALPHA_SIZE, 32'(PHASE_RADIX[n / PER_PHASE]));
                write_reg(REG_MAX_LEN, 32'(PHASE_LEN[n / PER_PHASE]));
            end
            else if (n % 50 == 25)
                settle(1'b0);
            steady_stretch = (n >= 120 && n < 220);

            c                = '0;
            c.symbol_index   = 8'($urandom);
            c.symbol_char    = 8'($urandom);
            c.seed_number    = {$urandom, $urandom};
            pick             = $urandom_range(0, 99);
            if (burst > 0)
            begin
                burst--;
                pick = 0;
            end

            if (pick < 55)
            begin
                c.operation = OP_STEP;
                load_missing();
            end
            else if (pick < 75)
            begin
                c.operation = OP_SEED;
                burst       = $urandom_range(1, 6);
                rdx         = eff_radix();
                case ($urandom_range(0, 4))
                    0: seed_num = 64'($urandom_range(0, 400));
                    1:
                    begin
                        // Land on or just below a length boundary of the current radix
                        pw    = 64'd1;
                        acc   = '0;
                        reach = $urandom_range(1, 17);
                        for (int j = 0; j < reach; j++)
                        begin
                            if (pw > ALL_ONES / rdx)
                            begin
                                acc = ALL_ONES;
                                break;
                            end
                            pw  *= rdx;
                            acc += pw;
                            if (acc < pw)
                            begin
                                acc = ALL_ONES;
                                break;
                            end
                        end
                        seed_num = (acc > 64'd2) ? acc - 64'($urandom_range(0, 2)) : acc;
                    end
                    2: seed_num = {$urandom, $urandom};
                    3: seed_num = {32'd0, $urandom};
                    default: seed_num = $urandom_range(0, 1) ? ALL_ONES : '0;
                endcase
                c.seed_number = seed_num;
            end
            else if (pick < 94)
                c.operation = OP_LOAD;
            else
                c.operation = pce_op_t'(OP_UNUSED);
            send_item(c);
        end

        // Drain, let the block fall quiet, then report
        settle(1'b1);
        if (expected_chars.size() != 0)
            report_mismatch("characters never delivered", 64'(expected_chars.size()), '0);
        $display("Run covered %0d accepted items: %0d candidate characters, %0d exhausted steps",
                 item_count, char_count, exhausted_count);
        $display("Visited %0d register settings plus directed clamps; longest candidate %0d",
                 PHASES, longest);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
